FILE: sv/b2b_pkg.sv
// Package for the BLAKE2b-512 hash core: payload types, IV, sigma table,
// sequencer states and the G half-step function. No dependencies.
package b2b_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_ROUND, ST_FOLD, ST_EMIT
  } state_e;

  localparam int unsigned NumRounds = 12;
  localparam logic [63:0] ParamWord = 64'h0000_0000_0101_0040;

  function automatic logic [63:0] iv_word(input logic [2:0] i);
    logic [63:0] v;
    case (i)
      3'd0: v = 64'h6a09e667f3bcc908;
      3'd1: v = 64'hbb67ae8584caa73b;
      3'd2: v = 64'h3c6ef372fe94f82b;
      3'd3: v = 64'ha54ff53a5f1d36f1;
      3'd4: v = 64'h510e527fade682d1;
      3'd5: v = 64'h9b05688c2b3e6c1f;
      3'd6: v = 64'h1f83d9abfb41bd6b;
      default: v = 64'h5be0cd19137e2179;
    endcase
    return v;
  endfunction

  // Message schedule: round r (0..11), slot s (0..15) -> buffer index.
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
    logic [63:0] row;
    case (r)
      4'd0, 4'd10: row = 64'hfedcba9876543210;
      4'd1, 4'd11: row = 64'h357b20c16df984ae;
      4'd2:  row = 64'h491763eadf250c8b;
      4'd3:  row = 64'h8f04a562ebcd1397;
      4'd4:  row = 64'hd386cb1efa427509;
      4'd5:  row = 64'h91ef57d438b0a6c2;
      4'd6:  row = 64'hb8293670a4def15c;
      4'd7:  row = 64'ha2684f05931ce7bd;
      4'd8:  row = 64'h5a417d2c803b9ef6;
      default: row = 64'h0dc3e9bf5167482a;
    endcase
    return row[{s, 2'b00} +: 4];
  endfunction

  typedef struct packed {
    logic [63:0] a, b, c, d;
  } quad_t;

  // Half of G: one message word, rotations (r1, r2) = (32,24) or (16,63).
  function automatic quad_t g_half(input quad_t q, input logic [63:0] m,
                                   input logic second);
    quad_t o;
    logic [63:0] t;
    o.a = q.a + q.b + m;
    t = q.d ^ o.a;
    o.d = second ? {t[15:0], t[63:16]} : {t[31:0], t[63:32]};
    o.c = q.c + o.d;
    t = q.b ^ o.c;
    o.b = second ? {t[62:0], t[63]} : {t[23:0], t[63:24]};
    return o;
  endfunction

endpackage

FILE: sv/b2b_round_unit.sv
// Shared G unit of the BLAKE2b core: applies one half of G to a column
// or diagonal of the work vector. Depends on b2b_pkg.
module b2b_round_unit (
  input  b2b_pkg::quad_t     q_i,
  input  logic [63:0]        m_i,
  input  logic               second_i,
  output b2b_pkg::quad_t     q_o
);
  import b2b_pkg::*;
  assign q_o = g_half(q_i, m_i, second_i);
endmodule

FILE: sv/blake2b_512_hash_core.sv
// BLAKE2b-512 hash core (unkeyed, 64-byte digest). Uses b2b_pkg and
// b2b_round_unit.
//
// Input channel: one 64-bit little-endian message word per handshake with
// a byte count and a last flag; a word is taken when in_valid_i is high
// and in_stall_o is low. Words are stored in a 16-entry block buffer.
// A full buffer is compressed only when a further word arrives, so the
// last block always gets the final flag.
// Compression runs the three 64-bit adders of one shared half-G unit:
// each cycle does one half of G on one column or diagonal; a block is
// ST_INIT, NumRounds rounds over all columns and diagonals, and ST_FOLD.
// A non-last word is stored at once, or waits while a full buffer is
// first compressed. The last word is followed by compression, twice
// when it carries bytes and lands on a full buffer, then eight output
// digest words, word 0 first, one per cycle that out_stall_i is low.
// While compressing or emitting, in_stall_o is high. A stalled output
// word holds its value. After the eighth digest word the core is back in
// its reset state for the next message.
// Reset (rst_ni low) restores the IV chain, clears the counters and
// drops out_valid_o; the block buffer needs no clearing.
module blake2b_512_hash_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b2b_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b2b_pkg::out_word_t  out_word_o
);
  import b2b_pkg::*;

  state_e      state_q, state_d;
  logic [63:0] h_q [8];
  logic [63:0] v_q [16];
  logic [63:0] buf_q [16];
  logic [63:0] total_q;
  logic [4:0]  held_q;
  logic        final_q;       // compression in flight is the final one
  logic        pend_q;        // a word waits to be stored after a flush
  logic [63:0] pend_word_q;
  logic [3:0]  pend_cnt_q;
  logic        pend_last_q;
  logic [3:0]  round_q;
  logic [2:0]  grp_q;         // G index 0..7
  logic        half_q;
  logic [2:0]  emit_q;

  // Accepted word after masking and clamping.
  logic        accept;
  logic [3:0]  cnt;
  logic [63:0] mword;
  always_comb begin
    accept = in_valid_i && !in_stall_o;
    cnt = in_word_i.last_word ? ((in_word_i.byte_count > 4'd8) ? 4'd8
                                 : in_word_i.byte_count) : 4'd8;
    mword = in_word_i.message_word;
    for (int k = 0; k < 8; k++)
      if (k[3:0] >= cnt) mword[8*k +: 8] = 8'h00;
  end

  // Work vector selection for the shared G unit.
  logic [3:0] ia, ib, ic, id;
  quad_t      q_in, q_out;
  logic [63:0] m_sel;
  logic [3:0]  slot;
  always_comb begin
    if (!grp_q[2]) begin
      ia = {2'b00, grp_q[1:0]};
      ib = 4'd4 + {2'b00, grp_q[1:0]};
      ic = 4'd8 + {2'b00, grp_q[1:0]};
      id = 4'd12 + {2'b00, grp_q[1:0]};
    end else begin
      ia = {2'b00, grp_q[1:0]};
      ib = {2'b01, grp_q[1:0] + 2'd1};
      ic = {2'b10, grp_q[1:0] + 2'd2};
      id = {2'b11, grp_q[1:0] + 2'd3};
    end
    q_in = '{a: v_q[ia], b: v_q[ib], c: v_q[ic], d: v_q[id]};
    slot = {grp_q, half_q};
    m_sel = buf_q[sigma(round_q, slot)];
  end

  b2b_round_unit u_g (
    .q_i      (q_in),
    .m_i      (m_sel),
    .second_i (half_q),
    .q_o      (q_out)
  );

  // Next state.
  logic round_done;
  assign round_done = (grp_q == 3'd7) && half_q && (round_q == 4'(NumRounds - 1));
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && ((held_q[4] && cnt != 4'd0) || in_word_i.last_word))
          state_d = ST_INIT;
      end
      ST_INIT:  state_d = ST_ROUND;
      ST_ROUND: if (round_done) state_d = ST_FOLD;
      ST_FOLD: begin
        // A flushed word that was also last restarts as the final block.
        if (pend_q && pend_last_q) state_d = ST_INIT;
        else if (final_q && !pend_q) state_d = ST_EMIT;
        else state_d = ST_IDLE;
      end
      ST_EMIT:  if (!out_stall_i && emit_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_EMIT);
    out_word_o.digest_word = h_q[emit_q];
    out_word_o.word_index = emit_q;
    out_word_o.digest_last = (emit_q == 3'd7);
  end

  // Byte count of the final block for a given held count and tail.
  function automatic logic [63:0] final_bytes(input logic [4:0] held,
                                              input logic [3:0] tail);
    logic [7:0] n;
    n = (tail != 4'd0) ? ({held - 5'd1, 3'b000} + {4'd0, tail})
                       : {held, 3'b000};
    return {56'd0, n};
  endfunction

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept && cnt != 4'd0 && !held_q[4])
      buf_q[held_q[3:0]] <= mword;
    else if (state_q == ST_FOLD && pend_q)
      buf_q[0] <= pend_word_q;
    else if (state_q == ST_INIT && final_q)
      for (int k = 0; k < 16; k++)
        if (5'(k) >= held_q) buf_q[k] <= '0;
    if (state_q == ST_IDLE && accept) begin
      pend_word_q <= mword;
      pend_cnt_q <= cnt;
    end
    if (state_q == ST_INIT) begin
      for (int k = 0; k < 8; k++) begin
        v_q[k] <= h_q[k];
        v_q[k+8] <= iv_word(3'(k)) ^ ((k == 4) ? total_q : 64'd0)
                    ^ ((k == 6 && final_q) ? '1 : 64'd0);
      end
    end else if (state_q == ST_ROUND) begin
      v_q[ia] <= q_out.a;
      v_q[ib] <= q_out.b;
      v_q[ic] <= q_out.c;
      v_q[id] <= q_out.d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int k = 0; k < 8; k++)
        h_q[k] <= iv_word(3'(k)) ^ ((k == 0) ? ParamWord : 64'd0);
      total_q <= '0;
      held_q <= '0;
      final_q <= 1'b0;
      pend_q <= 1'b0;
      round_q <= '0;
      grp_q <= '0;
      half_q <= 1'b0;
      emit_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (cnt != 4'd0 && held_q[4]) begin
              // Flush the full buffer first; the new word waits.
              pend_q <= 1'b1;
              final_q <= 1'b0;
              total_q <= total_q + 64'd128;
            end else begin
              final_q <= in_word_i.last_word;
              if (cnt != 4'd0) begin
                held_q <= held_q + 5'd1;
                if (in_word_i.last_word)
                  total_q <= total_q + final_bytes(held_q + 5'd1, cnt[3] ? 4'd0 : cnt);
              end else if (in_word_i.last_word) begin
                total_q <= total_q + final_bytes(held_q, 4'd0);
              end
            end
          end
        end
        ST_INIT: begin
          round_q <= '0;
          grp_q <= '0;
          half_q <= 1'b0;
        end
        ST_ROUND: begin
          half_q <= ~half_q;
          if (half_q) begin
            grp_q <= grp_q + 3'd1;
            if (grp_q == 3'd7) round_q <= round_q + 4'd1;
          end
        end
        ST_FOLD: begin
          for (int k = 0; k < 8; k++) h_q[k] <= h_q[k] ^ v_q[k] ^ v_q[k+8];
          if (pend_q) begin
            pend_q <= 1'b0;
            held_q <= 5'd1;
            final_q <= pend_last_q;
            // A flushed word that was also last restarts as the final block.
            if (pend_last_q)
              total_q <= total_q + final_bytes(5'd1, pend_cnt_q[3] ? 4'd0 : pend_cnt_q);
          end
          emit_q <= '0;
        end
        ST_EMIT: begin
          if (!out_stall_i) begin
            emit_q <= emit_q + 3'd1;
            if (emit_q == 3'd7) begin
              for (int k = 0; k < 8; k++)
                h_q[k] <= iv_word(3'(k)) ^ ((k == 0) ? ParamWord : 64'd0);
              total_q <= '0;
              held_q <= '0;
              final_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_last_q <= 1'b0;
    else if (state_q == ST_IDLE && accept) pend_last_q <= in_word_i.last_word;
  end

endmodule
